// ===== sv/stq_pkg.sv =====
// ============================================================================
// stq_pkg
// Shared widths, register indexes, the configuration bundle and width helpers
// for the smooth terrace quantiser.
// ============================================================================
package stq_pkg;

   // Sample and level width (signed, fixed point).
   localparam int SAMPLE_W = 18;
   // Tier count register width and the signed step count derived from it.
   localparam int TIER_W   = 9;
   localparam int STEP_W   = TIER_W + 1;
   // Product of a sample and a step count.
   localparam int SCALED_W = SAMPLE_W + STEP_W;
   // Divisor is twice the step count.
   localparam int DEN_W    = TIER_W + 1;
   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TIER_W;

   localparam logic [SAMPLE_W-1:0] LEVEL_MAX_Q = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] LEVEL_MIN_Q = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIER_COUNT    = 2'd0,
      CSR_SMOOTH_ENABLE = 2'd1
   } csr_index_type;

   // Settings seen by the datapath, derived from the configuration registers.
   typedef struct packed {
      logic [STEP_W-1:0] steps;   // two's complement step count
      logic              smooth;  // quintic blend selected
      logic              invalid; // step count is zero or negative
   } cfg_type;

   // Signed width of floor plus fade.
   function automatic int total_width(input int frac_bits);
      int w;
      w = (SCALED_W > frac_bits + 6) ? SCALED_W : frac_bits + 6;
      return w + 1;
   endfunction

   // Signed width of the rounding numerator, also the quotient width.
   function automatic int num_width(input int frac_bits);
      return total_width(frac_bits) + 2;
   endfunction

endpackage

// ===== sv/stq_fade.sv =====
// ============================================================================
// stq_fade
// Front pipeline: scales the sample, evaluates the quintic fade of the
// fraction and forms the signed rounding numerator as sign and magnitude.
// ============================================================================
module stq_fade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  stq_pkg::cfg_type                          cfg,
   input  logic                                      up_valid,
   output logic                                      up_ready,
   input  logic signed [stq_pkg::SAMPLE_W-1:0]       up_sample,
   output logic                                      down_valid,
   input  logic                                      down_ready,
   output logic                                      down_neg,
   output logic [stq_pkg::num_width(FRAC_BITS)-1:0]  down_mag
);

   localparam int F       = FRAC_BITS;
   localparam int INNER_W = F + 5;
   localparam int PROD_W  = INNER_W + F;
   localparam int TOT_W   = stq_pkg::total_width(F);
   localparam int NUM_W   = stq_pkg::num_width(F);
   localparam int NSTAGE  = 7;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (F - 1);

   logic [1:NSTAGE]   v_ff;
   logic [1:NSTAGE+1] load;

   logic signed [stq_pkg::SCALED_W-1:0] scaled_ff [1:6];
   logic [F-1:0]                        frac_ff   [1:6];
   logic [F:0]                          sq_ff;
   logic [INNER_W-1:0]                  inner_ff;
   logic [INNER_W-1:0]                  u4_ff;
   logic [INNER_W-1:0]                  u5_ff;
   logic [INNER_W-1:0]                  fade_ff;
   logic                                neg_ff;
   logic [NUM_W-1:0]                    mag_ff;

   logic signed [stq_pkg::SCALED_W-1:0]   scaled_in;
   logic signed [stq_pkg::SCALED_W+F-1:0] scaled_ext;
   logic [2*F:0]                          sq_prod;
   logic [F:0]                            sq_in;
   logic [INNER_W-1:0]                    inner_in;
   logic [PROD_W-1:0]                     p4, p5, p6;
   logic [INNER_W-1:0]                    fade_sel;
   logic signed [TOT_W-1:0]               total;
   logic signed [NUM_W-1:0]               tot_ext;
   logic signed [NUM_W-1:0]               num;

   always_comb begin
      load[NSTAGE+1] = down_ready;
      for (int k = NSTAGE; k >= 1; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
   end

   assign up_ready   = load[1];
   assign down_valid = v_ff[NSTAGE];
   assign down_neg   = neg_ff;
   assign down_mag   = mag_ff;

   // Stage arithmetic: scale, square, inner polynomial, three fraction products, numerator.
   always_comb begin
      scaled_in  = up_sample * $signed(cfg.steps);
      scaled_ext = (stq_pkg::SCALED_W + F)'(scaled_in);
      sq_prod    = (2*F+1)'(frac_ff[1]) * (2*F+1)'(frac_ff[1]) + (2*F+1)'(HALF);
      sq_in      = sq_prod[2*F:F];
      inner_in   = INNER_W'(sq_ff) * INNER_W'(6) + (INNER_W'(10) << F)
                   - INNER_W'(frac_ff[2]) * INNER_W'(15);
      p4         = PROD_W'(inner_ff) * PROD_W'(frac_ff[3]) + HALF;
      p5         = PROD_W'(u4_ff) * PROD_W'(frac_ff[4]) + HALF;
      p6         = PROD_W'(u5_ff) * PROD_W'(frac_ff[5]) + HALF;
      fade_sel   = cfg.smooth ? fade_ff : '0;
      total      = TOT_W'(scaled_ff[6]) - $signed(TOT_W'(frac_ff[6]))
                   + $signed(TOT_W'(fade_sel));
      tot_ext    = NUM_W'(total);
      num        = (tot_ext <<< 1) + NUM_W'($signed(cfg.steps));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (load[1]) begin
            v_ff[1] <= up_valid;
         end
         for (int k = 2; k <= NSTAGE; k++) begin
            if (load[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         scaled_ff[1] <= scaled_in;
         frac_ff[1]   <= scaled_ext[F-1:0];
      end
      for (int k = 2; k <= 6; k++) begin
         if (load[k]) begin
            scaled_ff[k] <= scaled_ff[k-1];
            frac_ff[k]   <= frac_ff[k-1];
         end
      end
      if (load[2]) begin
         sq_ff <= sq_in;
      end
      if (load[3]) begin
         inner_ff <= inner_in;
      end
      if (load[4]) begin
         u4_ff <= p4[PROD_W-1:F];
      end
      if (load[5]) begin
         u5_ff <= p5[PROD_W-1:F];
      end
      if (load[6]) begin
         fade_ff <= p6[PROD_W-1:F];
      end
      if (load[7]) begin
         neg_ff <= num[NUM_W-1];
         mag_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      end
   end

endmodule

// ===== sv/stq_div_cell.sv =====
// ============================================================================
// stq_div_cell
// One cell of the restoring divider chain: develops one quotient bit per
// request and hands the partial remainder on to the next cell.
// ============================================================================
module stq_div_cell #(
   parameter int NQ_W = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [stq_pkg::DEN_W-1:0]      den,
   input  logic                           up_valid,
   output logic                           up_ready,
   input  logic                           up_neg,
   input  logic [NQ_W-1:0]                up_nq,
   input  logic [stq_pkg::DEN_W-1:0]      up_rem,
   output logic                           down_valid,
   input  logic                           down_ready,
   output logic                           down_neg,
   output logic [NQ_W-1:0]                down_nq,
   output logic [stq_pkg::DEN_W-1:0]      down_rem
);

   localparam int DW = stq_pkg::DEN_W;

   logic            valid_ff;
   logic            neg_ff;
   logic [NQ_W-1:0] nq_ff;
   logic [DW-1:0]   rem_ff;

   logic            load;
   logic [DW:0]     shifted;
   logic [DW:0]     diff;
   logic            fits;

   assign load     = !valid_ff || down_ready;
   assign up_ready = load;

   // The numerator bits leave at the top while quotient bits enter below.
   always_comb begin
      shifted = {up_rem, up_nq[NQ_W-1]};
      diff    = shifted - {1'b0, den};
      fits    = shifted >= {1'b0, den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff <= up_neg;
         nq_ff  <= {up_nq[NQ_W-2:0], fits};
         rem_ff <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      end
   end

   assign down_valid = valid_ff;
   assign down_neg   = neg_ff;
   assign down_nq    = nq_ff;
   assign down_rem   = rem_ff;

endmodule

// ===== sv/smooth_terrace_quantizer.sv =====
// ============================================================================
// smooth_terrace_quantizer
// Quantises signed fixed-point noise samples into terrace levels, with an
// optional quintic blend between neighbouring levels.
// ============================================================================
// Usage. Requests arrive on req_valid/req_ready carrying req_sample, a signed
// value with FRAC_BITS fraction bits. Each request yields exactly one
// response on rsp_valid/rsp_ready carrying rsp_level and rsp_invalid, in
// request order. The tier count and the smooth flag are written through the
// csr_ port (index 0 and index 1) while no request is in flight.
// Throughput is one request per cycle while rsp_ready stays high. A request
// passes through seven front stages for scaling and the fade polynomial,
// one divider cell per quotient bit, and the output register.
// The divider chain is set by the numerator width, one cell per bit.
// Each stage holds its request until the next stage can take it, so bubbles
// close up when the receiver stalls and requests keep being accepted until
// every stage is full; req_ready then drops until rsp_ready returns.
// Reset clears every stage valid bit, sets the tier count to zero and
// enables smoothing, so an unconfigured block flags every response invalid.
// ============================================================================
module smooth_terrace_quantizer #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [stq_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [stq_pkg::SAMPLE_W-1:0]   rsp_level,
   output logic                                  rsp_invalid,
   input  logic                                  csr_write_enable,
   input  logic [stq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [stq_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int NUM_W = stq_pkg::num_width(FRAC_BITS);
   localparam int SW    = stq_pkg::SAMPLE_W;
   localparam int DW    = stq_pkg::DEN_W;

   // Configuration registers.
   logic [stq_pkg::TIER_W-1:0] tier_count_ff;
   logic                       smooth_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tier_count_ff    <= '0;
         smooth_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            stq_pkg::CSR_TIER_COUNT: begin
               tier_count_ff <= csr_write_data;
            end
            stq_pkg::CSR_SMOOTH_ENABLE: begin
               smooth_enable_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // The step count is one less than the tier count in smooth mode. The user
   // must change the registers only while the block is idle, which the block
   // does not enforce. Every stage reads them directly, not a per-request copy.
   stq_pkg::cfg_type  cfg;
   logic [DW-1:0]     den;

   always_comb begin
      cfg.steps   = {1'b0, tier_count_ff} - stq_pkg::STEP_W'(smooth_enable_ff);
      cfg.smooth  = smooth_enable_ff;
      cfg.invalid = cfg.steps[stq_pkg::STEP_W-1] || (cfg.steps == '0);
      den         = {cfg.steps[stq_pkg::TIER_W-1:0], 1'b0};
   end

   // Chain boundaries: index 0 is the front pipeline output, index NUM_W
   // the last divider cell.
   logic             c_valid [0:NUM_W];
   logic             c_ready [0:NUM_W];
   logic             c_neg   [0:NUM_W];
   logic [NUM_W-1:0] c_nq    [0:NUM_W];
   logic [DW-1:0]    c_rem   [0:NUM_W];

   stq_fade #(
      .FRAC_BITS (FRAC_BITS)
   ) u_fade (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .up_sample  (req_sample),
      .down_valid (c_valid[0]),
      .down_ready (c_ready[0]),
      .down_neg   (c_neg[0]),
      .down_mag   (c_nq[0])
   );

   assign c_rem[0] = '0;

   for (genvar k = 0; k < NUM_W; k++) begin : g_cell
      stq_div_cell #(
         .NQ_W (NUM_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .den        (den),
         .up_valid   (c_valid[k]),
         .up_ready   (c_ready[k]),
         .up_neg     (c_neg[k]),
         .up_nq      (c_nq[k]),
         .up_rem     (c_rem[k]),
         .down_valid (c_valid[k+1]),
         .down_ready (c_ready[k+1]),
         .down_neg   (c_neg[k+1]),
         .down_nq    (c_nq[k+1]),
         .down_rem   (c_rem[k+1])
      );
   end

   // Output register. The chain gives the truncated quotient of the
   // magnitude; a negative numerator with a remainder rounds one further
   // away from zero so that the overall result is the floor.
   logic          rsp_valid_ff;
   logic [SW-1:0] level_ff;
   logic          invalid_ff;
   logic          load_out;
   logic [NUM_W:0] mag_q;
   logic [NUM_W:0] neg_q;
   logic [SW-1:0]  level_in;

   assign load_out       = !rsp_valid_ff || rsp_ready;
   assign c_ready[NUM_W] = load_out;

   always_comb begin
      mag_q = {1'b0, c_nq[NUM_W]}
              + (NUM_W+1)'(c_neg[NUM_W] && (c_rem[NUM_W] != '0));
      neg_q = -mag_q;
      if (cfg.invalid) begin
         level_in = '0;
      end else if (c_neg[NUM_W]) begin
         if (mag_q > (NUM_W+1)'(stq_pkg::LEVEL_MIN_Q)) begin
            level_in = stq_pkg::LEVEL_MIN_Q;
         end else begin
            level_in = neg_q[SW-1:0];
         end
      end else begin
         if (mag_q > (NUM_W+1)'(stq_pkg::LEVEL_MAX_Q)) begin
            level_in = stq_pkg::LEVEL_MAX_Q;
         end else begin
            level_in = mag_q[SW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= c_valid[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         level_ff   <= level_in;
         invalid_ff <= cfg.invalid;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_level   = $signed(level_ff);
   assign rsp_invalid = invalid_ff;

endmodule

// ===== sim/smooth_terrace_quantizer_tb.sv =====
// ============================================================================
// smooth_terrace_quantizer_tb
// Self-checking testbench for the terrace quantiser. A short table of directed
// requests covers the register extremes, invalid step counts, saturation and
// ignored register indexes. It is followed by random phases, each with its own
// tier count and blend setting. Every response is compared with the value given
// in the table or with an independent integer predictor.
// ============================================================================
module smooth_terrace_quantizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Fraction bits of the fixed-point format, and the figures derived from it.
   localparam int FRAC_BITS    = 16;
   localparam int PIPE_LATENCY = ((28 > FRAC_BITS + 6) ? 28 : FRAC_BITS + 6) + 11;

   localparam longint unsigned ONE_FIXED  = 64'd1 << FRAC_BITS;
   localparam longint unsigned FRAC_MASK  = ONE_FIXED - 64'd1;
   localparam longint unsigned HALF_FIXED = ONE_FIXED >> 1;
   localparam longint          FLOOR_BIAS = 64'sd1 << 28;

   localparam int SAMPLE_MAX = 131071;
   localparam int SAMPLE_MIN = -131072;
   localparam int ONE_Q      = 65536;
   localparam int TIER_MAX   = 511;

   // Register indexes that decode to nothing and must be ignored.
   localparam logic [stq_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [stq_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // Run shape.
   localparam int RANDOM_PHASES    = 14;
   localparam int PHASE_ITEMS      = 72;
   localparam int PRESSURE_ITEMS   = 120;
   localparam int PRESSURE_PHASE   = 2;
   localparam int MID_DRAIN_PHASE  = 5;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT      = 4000;

   typedef struct packed {
      logic signed [stq_pkg::SAMPLE_W-1:0] level;
      logic                                invalid;
   } terrace_result_type;

   typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // One row of the directed table. Rows with typed set carry the response
   // that must come back; all others are checked against the predictor.
   typedef struct {
      row_kind_type                   kind;
      logic [stq_pkg::CSR_IDX_W-1:0]  index;
      logic [stq_pkg::CSR_DATA_W-1:0] data;
      int                             sample;
      bit                             typed;
      int                             level;
      bit                             invalid;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 34;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // Straight out of reset the step count is negative: every response is flagged.
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   0,          1, 0,          1},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MAX, 1, 0,          1},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MIN, 1, 0,          1},
      // One tier with blending leaves a step count of zero.
      '{ROW_WRITE,  stq_pkg::CSR_TIER_COUNT,    9'd1,   0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   ONE_Q,      1, 0,          1},
      // Hard steps with a single step: the level is the floor of the sample.
      '{ROW_WRITE,  stq_pkg::CSR_SMOOTH_ENABLE, 9'd0,   0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   ONE_Q,      1, ONE_Q,      0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MIN, 1, SAMPLE_MIN, 0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MAX, 0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   -1,         0, 0,          0},
      // Zero tiers in hard mode.
      '{ROW_WRITE,  stq_pkg::CSR_TIER_COUNT,    9'd0,   0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   -77,        1, 0,          1},
      // Largest tier count, well beyond the nominal range.
      '{ROW_WRITE,  stq_pkg::CSR_TIER_COUNT,    9'd511, 0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MIN, 1, SAMPLE_MIN, 0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MAX, 0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   1,          0, 0,          0},
      '{ROW_WRITE,  stq_pkg::CSR_SMOOTH_ENABLE, 9'd1,   0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MAX, 0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MIN, 1, SAMPLE_MIN, 0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   -1,         0, 0,          0},
      // Writes to indexes beyond the two registers must change nothing.
      '{ROW_WRITE,  CSR_SPARE_2,                9'd511, 0,          0, 0,          0},
      '{ROW_WRITE,  CSR_SPARE_3,                9'd0,   0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   4660,       0, 0,          0},
      // Two tiers with blending: the top of the range saturates.
      '{ROW_WRITE,  stq_pkg::CSR_TIER_COUNT,    9'd2,   0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   SAMPLE_MAX, 0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   ONE_Q / 2,  0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   -ONE_Q / 2, 0, 0,          0},
      '{ROW_WRITE,  stq_pkg::CSR_TIER_COUNT,    9'd256, 0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   65535,      0, 0,          0},
      // Only bit zero of the blend register counts.
      '{ROW_WRITE,  stq_pkg::CSR_SMOOTH_ENABLE, 9'h1FE, 0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   12345,      0, 0,          0},
      '{ROW_WRITE,  stq_pkg::CSR_TIER_COUNT,    9'd3,   0,          0, 0,          0},
      '{ROW_WRITE,  stq_pkg::CSR_SMOOTH_ENABLE, 9'd1,   0,          0, 0,          0},
      '{ROW_SAMPLE, stq_pkg::CSR_TIER_COUNT,    9'd0,   98304,      0, 0,          0}
   };

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [stq_pkg::SAMPLE_W-1:0] req_sample;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [stq_pkg::SAMPLE_W-1:0] rsp_level;
   logic                                rsp_invalid;
   logic                                csr_write_enable;
   logic [stq_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [stq_pkg::CSR_DATA_W-1:0]      csr_write_data;

   // The testbench's own copy of the two registers.
   logic [stq_pkg::CSR_DATA_W-1:0]      tier_setting;
   logic                                smooth_setting;

   // Responses still owed by the block, oldest first.
   terrace_result_type                  outstanding_levels [$];
   int                                  mismatch_count = 0;

   // Set by the stimulus to ask the response side for one long hold-off.
   bit                                  long_hold_request = 1'b0;
   // Remaining length of the current stretch without gaps, on each side.
   int                                  tx_calm_left = 0;
   int                                  rx_calm_left = 0;

   smooth_terrace_quantizer #(
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level        (rsp_level),
      .rsp_invalid      (rsp_invalid),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Product of two unsigned fixed-point values, rounded to nearest with
   // ties upward, back to the same format.
   function automatic longint unsigned mul_round_q(input longint unsigned a,
                                                   input longint unsigned b);
      return (a * b + HALF_FIXED) >> FRAC_BITS;
   endfunction

   // Quintic ramp 6f^5 - 15f^4 + 10f^3, evaluated as f^3 times the inner
   // polynomial, with every product rounded. The inner term never goes
   // negative, so unsigned arithmetic is safe throughout.
   function automatic longint unsigned smooth_ramp(input longint unsigned f);
      longint unsigned sq;
      longint unsigned poly;
      longint unsigned acc;
      sq   = mul_round_q(f, f);
      poly = 6 * sq + 10 * ONE_FIXED - 15 * f;
      acc  = mul_round_q(poly, f);
      acc  = mul_round_q(acc, f);
      return mul_round_q(acc, f);
   endfunction

   // Expected response for one sample under the current register settings.
   function automatic terrace_result_type predict_terrace(
      input logic signed [stq_pkg::SAMPLE_W-1:0] sample);
      terrace_result_type res;
      longint             steps;
      longint             scaled;
      longint             total;
      longint             num;
      longint             den;
      longint             lvl;
      longint unsigned    frac;
      longint unsigned    ramp;
      steps = longint'(tier_setting) - longint'(smooth_setting);
      if (steps <= 0) begin
         res.level   = '0;
         res.invalid = 1'b1;
         return res;
      end
      scaled = longint'(sample) * steps;
      // The fraction is the low bits of the two's complement product, which
      // makes the floor correct for negative values as well.
      frac   = longint'(unsigned'(scaled)) & FRAC_MASK;
      ramp   = smooth_setting ? smooth_ramp(frac) : 64'd0;
      total  = scaled - longint'(frac) + longint'(ramp);
      // Round to nearest with ties upward: floor((2*total + steps) / 2*steps).
      // The bias keeps the dividend positive so truncation acts as floor.
      num    = 2 * total + steps;
      den    = 2 * steps;
      lvl    = (num + den * FLOOR_BIAS) / den - FLOOR_BIAS;
      if (lvl > SAMPLE_MAX) lvl = SAMPLE_MAX;
      if (lvl < SAMPLE_MIN) lvl = SAMPLE_MIN;
      res.level   = lvl[stq_pkg::SAMPLE_W-1:0];
      res.invalid = 1'b0;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Idle length before the next request or the next ready cycle. Mostly
   // nothing or a few cycles, now and then a long one, and from time to time
   // a stretch with no gaps at all.
   function automatic int draw_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(10, 60);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [stq_pkg::SAMPLE_W-1:0] random_sample();
      int s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: s = SAMPLE_MAX;
               1: s = SAMPLE_MIN;
               2: s = 0;
               3: s = -1;
               4: s = ONE_Q;
               default: s = -ONE_Q;
            endcase
         end
         1, 2: s = int'($urandom_range(0, 4096)) - 2048;
         default: s = $urandom;
      endcase
      return stq_pkg::SAMPLE_W'(s);
   endfunction

   // Tier counts favour the usable range but visit the invalid and the
   // oversized settings too.
   function automatic logic [stq_pkg::CSR_DATA_W-1:0] random_tier();
      int t;
      case ($urandom_range(0, 15))
         0: t = 0;
         1: t = 1;
         2: t = 2;
         3: t = TIER_MAX;
         4: t = 256;
         5, 6: t = $urandom_range(257, TIER_MAX);
         default: t = $urandom_range(3, 256);
      endcase
      return stq_pkg::CSR_DATA_W'(t);
   endfunction

   // Presents one request after the given number of idle cycles and waits
   // for it to be taken. The expected response is queued at the accepting
   // edge, either as given or from the predictor.
   task automatic offer_sample(input logic signed [stq_pkg::SAMPLE_W-1:0] sample,
                               input int gap,
                               input bit has_given,
                               input terrace_result_type given);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      outstanding_levels.push_back(has_given ? given : predict_terrace(sample));
   endtask

   // Stops offering requests and waits until every response has come back.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [stq_pkg::CSR_IDX_W-1:0] idx,
                            input logic [stq_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         stq_pkg::CSR_TIER_COUNT:    tier_setting   = data;
         stq_pkg::CSR_SMOOTH_ENABLE: smooth_setting = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Request side: directed table, then random phases
   // ------------------------------------------------------------------------
   initial begin : request_side
      terrace_result_type              given;
      terrace_result_type              none;
      logic [stq_pkg::CSR_DATA_W-1:0]  blend_data;
      int                              items;
      int                              gap;

      none             = '0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      csr_write_enable = 1'b0;
      csr_index        = stq_pkg::CSR_TIER_COUNT;
      csr_write_data   = '0;
      tier_setting     = '0;
      smooth_setting   = 1'b1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle_block();
            write_csr(directed_rows[i].index, directed_rows[i].data);
         end else begin
            given.level   = stq_pkg::SAMPLE_W'(directed_rows[i].level);
            given.invalid = directed_rows[i].invalid;
            offer_sample(stq_pkg::SAMPLE_W'(directed_rows[i].sample),
                         draw_gap(tx_calm_left), directed_rows[i].typed, given);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Registers only change once the block has handed back everything.
         settle_block();
         write_csr(stq_pkg::CSR_TIER_COUNT, random_tier());
         // The blend register sometimes carries junk in its upper bits.
         blend_data    = $urandom_range(0, 1) ? stq_pkg::CSR_DATA_W'($urandom) : '0;
         blend_data[0] = 1'($urandom_range(0, 1));
         write_csr(stq_pkg::CSR_SMOOTH_ENABLE, blend_data);
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                      stq_pkg::CSR_DATA_W'($urandom));

         items = (phase == PRESSURE_PHASE) ? PRESSURE_ITEMS : PHASE_ITEMS;
         // In the pressure phase the response side holds off for a long
         // time while requests keep coming back to back, so the pipeline
         // fills and req_ready has to drop.
         if (phase == PRESSURE_PHASE) long_hold_request = 1'b1;

         for (int n = 0; n < items; n++) begin
            // Once, the sender pauses mid-phase until the block is empty.
            if (phase == MID_DRAIN_PHASE && n == items / 2) settle_block();
            gap = (phase == PRESSURE_PHASE) ? 0 : draw_gap(tx_calm_left);
            offer_sample(random_sample(), gap, 1'b0, none);
         end
      end

      settle_block();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (outstanding_levels.size() != 0) begin
         $error("%0d responses never arrived", outstanding_levels.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random back-pressure and the field-by-field check
   // ------------------------------------------------------------------------
   initial begin : response_side
      int                 hold;
      terrace_result_type want;

      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold = LONG_HOLD_CYCLES;
         end else begin
            hold = draw_gap(rx_calm_left);
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid) begin
            if (outstanding_levels.size() == 0) begin
               $error("unexpected response: level %0d invalid %0b",
                      rsp_level, rsp_invalid);
               mismatch_count++;
            end else begin
               want = outstanding_levels.pop_front();
               if (rsp_level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, rsp_level);
                  mismatch_count++;
               end
               if (rsp_invalid !== want.invalid) begin
                  $error("invalid: expected %0b, got %0b", want.invalid, rsp_invalid);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run if neither channel moves for too long. The limit
   // covers the long hold-off, the longest gaps and the pipeline latency
   // several times over.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $error("no request or response accepted for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/stq_pkg.sv
sv/stq_fade.sv
sv/stq_div_cell.sv
sv/smooth_terrace_quantizer.sv
sim/smooth_terrace_quantizer_tb.sv
